FILE: rtl/core/vpa_pkg.sv
// package with shared types, constants and tables of the partition allocator
`timescale 1ns / 1ps
`default_nettype none

package vpa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int ADDR_WIDTH_DEF = 16;
    localparam int PARTITIONS_DEF = 4;

    localparam int PART_W    = 14;
    localparam int FIELD_W   = 16;
    localparam int OPC_W     = 3;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_IDX_W = 4;

    localparam logic [OPC_W-1:0] OPC_FIRST   = 3'd0;
    localparam logic [OPC_W-1:0] OPC_BEST    = 3'd1;
    localparam logic [OPC_W-1:0] OPC_WORST   = 3'd2;
    localparam logic [OPC_W-1:0] OPC_RELEASE = 3'd3;
    localparam logic [OPC_W-1:0] OPC_RELOAD  = 3'd4;

    typedef enum logic [2:0] {
        ST_ALLOCATED,
        ST_NO_FIT,
        ST_RELEASED,
        ST_NOT_FOUND,
        ST_TABLE_FULL,
        ST_RELOADED
    } status_t;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic zero;
        logic carry;
        logic c_lt_d;
        logic c_gt_d;
    } alu_flags_t;

    typedef struct packed {
        logic [OPC_W-1:0]   opcode;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] release_address;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [FIELD_W-1:0]   granted_address;
        logic [CNT_OUT_W-1:0] entries_in_use;
    } rsp_t;

    // partition sizes after reset
    function automatic logic [PART_W-1:0] part_reset(input int p);
        logic [PART_W-1:0] v;
        unique case (p)
            0:       v = 14'd100;
            1:       v = 14'd200;
            2:       v = 14'd50;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/variable_partition_allocator.sv
// top level of the variable partition allocator with its partition registers
`timescale 1ns / 1ps
`default_nettype none

// Keeps an address-ordered table of up to MAX_BLOCKS blocks in a single ram and
// serves first, best and worst fit allocation, release by start address and
// reload from the partition size registers, one transaction at a time with one
// response each. Every table read goes through the one ram read port, one
// entry per cycle. After reset, while the table is built from the reset
// partition sizes, req_ready stays low. Partition registers are written
// through cfg_wen, cfg_index and cfg_data; the user must write them only while
// no transaction is in flight, as the block itself does not enforce it.
module variable_partition_allocator #(
    parameter int MAX_BLOCKS = vpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_WIDTH = vpa_pkg::ADDR_WIDTH_DEF,
    parameter int PARTITIONS = vpa_pkg::PARTITIONS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [vpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vpa_pkg::PART_W-1:0]      cfg_data,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire vpa_pkg::req_t                   req_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output vpa_pkg::rsp_t                        rsp_data
);
    import vpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int SIZE_W = $clog2(PARTITIONS * (2 ** PART_W - 1) + 1);
    localparam int ENT_W  = 1 + SIZE_W + ADDR_WIDTH;
    localparam int MAX_AS = (ADDR_WIDTH > SIZE_W) ? ADDR_WIDTH : SIZE_W;
    localparam int OP_W   = (MAX_AS > FIELD_W) ? MAX_AS : FIELD_W;

    logic [PARTITIONS-1:0][PART_W-1:0] partition_size_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    alu_op_t          alu_op;
    logic [OP_W-1:0]  alu_a;
    logic [OP_W-1:0]  alu_b;
    logic [OP_W-1:0]  alu_c;
    logic [OP_W-1:0]  alu_d;
    logic [OP_W:0]    alu_res;
    alu_flags_t       alu_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PARTITIONS; p++)
            begin
                partition_size_reg[p] <= part_reset(p);
            end
        end
        else
        begin
            for (int p = 0; p < PARTITIONS; p++)
            begin
                if (cfg_wen && cfg_index == CFG_IDX_W'(p))
                begin
                    partition_size_reg[p] <= cfg_data;
                end
            end
        end
    end

    vpa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vpa_alu #(
        .W (OP_W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .d     (alu_d),
        .res   (alu_res),
        .flags (alu_flags)
    );

    vpa_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .PARTITIONS (PARTITIONS),
        .IDX_W      (IDX_W),
        .SIZE_W     (SIZE_W),
        .ENT_W      (ENT_W),
        .OP_W       (OP_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .partition_size (partition_size_reg),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .alu_op         (alu_op),
        .alu_a          (alu_a),
        .alu_b          (alu_b),
        .alu_c          (alu_c),
        .alu_d          (alu_d),
        .alu_res        (alu_res),
        .alu_flags      (alu_flags)
    );

endmodule

`default_nettype wire

FILE: rtl/core/vpa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/vpa_alu.sv
// shared add, subtract and compare unit of the allocator sequencer
`timescale 1ns / 1ps
`default_nettype none

module vpa_alu #(
    parameter int W = 17
) (
    input  wire vpa_pkg::alu_op_t    op,
    input  wire logic [W-1:0]        a,
    input  wire logic [W-1:0]        b,
    input  wire logic [W-1:0]        c,
    input  wire logic [W-1:0]        d,
    output logic      [W:0]          res,
    output vpa_pkg::alu_flags_t      flags
);
    import vpa_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_ADD: res = {1'b0, a} + {1'b0, b};
            ALU_SUB: res = {1'b0, a} - {1'b0, b};
            default: res = '0;
        endcase
        flags.zero   = (res[W-1:0] == '0);
        flags.carry  = res[W];
        flags.c_lt_d = (c < d);
        flags.c_gt_d = (c > d);
    end

endmodule

`default_nettype wire

FILE: rtl/core/vpa_seq.sv
// sequencer that scans, shifts, splits and merges the block table through the ram and rebuilds it on reload
`timescale 1ns / 1ps
`default_nettype none

module vpa_seq #(
    parameter int MAX_BLOCKS = vpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_WIDTH = vpa_pkg::ADDR_WIDTH_DEF,
    parameter int PARTITIONS = vpa_pkg::PARTITIONS_DEF,
    parameter int IDX_W      = $clog2(MAX_BLOCKS),
    parameter int SIZE_W     = $clog2(PARTITIONS * (2 ** vpa_pkg::PART_W - 1) + 1),
    parameter int ENT_W      = 1 + SIZE_W + ADDR_WIDTH,
    parameter int OP_W       = 17
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic [PARTITIONS-1:0][vpa_pkg::PART_W-1:0] partition_size,
    input  wire logic                                       req_valid,
    output logic                                            req_ready,
    input  wire vpa_pkg::req_t                              req_data,
    output logic                                            rsp_valid,
    input  wire logic                                       rsp_ready,
    output vpa_pkg::rsp_t                                   rsp_data,
    output logic                                            ram_we,
    output logic [IDX_W-1:0]                                ram_waddr,
    output logic [ENT_W-1:0]                                ram_wdata,
    output logic [IDX_W-1:0]                                ram_raddr,
    input  wire logic [ENT_W-1:0]                           ram_rdata,
    output vpa_pkg::alu_op_t                                alu_op,
    output logic [OP_W-1:0]                                 alu_a,
    output logic [OP_W-1:0]                                 alu_b,
    output logic [OP_W-1:0]                                 alu_c,
    output logic [OP_W-1:0]                                 alu_d,
    input  wire logic [OP_W:0]                              alu_res,
    input  wire vpa_pkg::alu_flags_t                        alu_flags
);
    import vpa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int PC_W  = $clog2(PARTITIONS + 1);
    localparam int CNT_X = CNT_W + CNT_OUT_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SPLIT,
        S_MARK,
        S_MERGE,
        S_MERGE_END,
        S_RELOAD,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [OPC_W-1:0]      opcode_reg, opcode_next;
    logic [FIELD_W-1:0]    req_size_reg, req_size_next;
    logic [FIELD_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]      ev_idx_reg, ev_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_idx_reg, pick_idx_next;
    logic [ADDR_WIDTH-1:0] pick_start_reg, pick_start_next;
    logic [SIZE_W-1:0]     pick_size_reg, pick_size_next;
    logic [SIZE_W-1:0]     pick_rem_reg, pick_rem_next;
    logic                  pick_exact_reg, pick_exact_next;
    logic [ADDR_WIDTH-1:0] hold_start_reg, hold_start_next;
    logic [SIZE_W-1:0]     hold_size_reg, hold_size_next;
    logic                  hold_used_reg, hold_used_next;
    logic [IDX_W-1:0]      wptr_reg, wptr_next;
    logic [ADDR_WIDTH-1:0] acc_reg, acc_next;
    logic [PC_W-1:0]       part_reg, part_next;
    status_t               res_status_reg, res_status_next;
    logic [FIELD_W-1:0]    res_granted_reg, res_granted_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg, rsp_data_next;

    logic                  rd_used;
    logic [SIZE_W-1:0]     rd_size;
    logic [ADDR_WIDTH-1:0] rd_start;
    logic [PART_W-1:0]     part_sz;
    logic [OP_W-1:0]       req_x;
    logic [OP_W-1:0]       pick_start_x;
    logic [CNT_X-1:0]      cnt_wide;
    logic                  issue;
    logic                  take;
    logic                  better;
    logic                  e_used;

    assign rd_used      = ram_rdata[ENT_W-1];
    assign rd_size      = ram_rdata[ADDR_WIDTH +: SIZE_W];
    assign rd_start     = ram_rdata[ADDR_WIDTH-1:0];
    assign req_x        = OP_W'(req_size_reg);
    assign pick_start_x = OP_W'(pick_start_reg);
    assign cnt_wide     = CNT_X'(count_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // partition size for the reload step, reset table while initializing
    always_comb
    begin
        part_sz = '0;
        for (int p = 0; p < PARTITIONS; p++)
        begin
            if (part_reg == PC_W'(p))
            begin
                part_sz = (state_reg == S_INIT) ? part_reset(p) : partition_size[p];
            end
        end
    end

    // operand select for the shared unit
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        alu_c  = '0;
        alu_d  = '0;
        unique case (state_reg)
            S_SCAN:
            begin
                alu_op = ALU_SUB;
                if (opcode_reg == OPC_RELEASE)
                begin
                    alu_a = OP_W'(rd_start);
                    alu_b = OP_W'(addr_reg);
                end
                else
                begin
                    alu_a = OP_W'(rd_size);
                    alu_b = req_x;
                    alu_c = OP_W'(rd_size);
                    alu_d = OP_W'(pick_size_reg);
                end
            end
            S_SPLIT:
            begin
                alu_a = pick_start_x;
                alu_b = req_x;
            end
            S_MERGE:
            begin
                alu_a = OP_W'(hold_size_reg);
                alu_b = OP_W'(rd_size);
            end
            S_INIT, S_RELOAD:
            begin
                alu_a = OP_W'(acc_reg);
                alu_b = OP_W'(part_sz);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        opcode_next      = opcode_reg;
        req_size_next    = req_size_reg;
        addr_next        = addr_reg;
        ptr_next         = ptr_reg;
        ev_vld_next      = ev_vld_reg;
        ev_idx_next      = ev_idx_reg;
        found_next       = found_reg;
        pick_idx_next    = pick_idx_reg;
        pick_start_next  = pick_start_reg;
        pick_size_next   = pick_size_reg;
        pick_rem_next    = pick_rem_reg;
        pick_exact_next  = pick_exact_reg;
        hold_start_next  = hold_start_reg;
        hold_size_next   = hold_size_reg;
        hold_used_next   = hold_used_reg;
        wptr_next        = wptr_reg;
        acc_next         = acc_reg;
        part_next        = part_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_data_next    = rsp_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;
        issue            = 1'b0;
        take             = 1'b0;
        better           = 1'b0;
        e_used           = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT, S_RELOAD:
            begin
                if (part_sz != '0)
                begin
                    if (count_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        ram_wdata  = {1'b0, SIZE_W'(part_sz), acc_reg};
                        count_next = count_reg + CNT_W'(1);
                    end
                    acc_next = alu_res[ADDR_WIDTH-1:0];
                end
                if (part_reg == PC_W'(PARTITIONS - 1))
                begin
                    res_status_next  = ST_RELOADED;
                    res_granted_next = '0;
                    state_next       = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
                else
                begin
                    part_next = part_reg + PC_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    opcode_next      = req_data.opcode;
                    req_size_next    = req_data.request_size;
                    addr_next        = req_data.release_address;
                    ptr_next         = '0;
                    ev_vld_next      = 1'b0;
                    found_next       = 1'b0;
                    res_granted_next = '0;
                    if (req_data.opcode == OPC_FIRST || req_data.opcode == OPC_BEST ||
                        req_data.opcode == OPC_WORST)
                    begin
                        if (req_data.request_size == '0)
                        begin
                            res_status_next = ST_NO_FIT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (req_data.opcode == OPC_RELEASE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req_data.opcode == OPC_RELOAD)
                    begin
                        count_next = '0;
                        acc_next   = '0;
                        part_next  = '0;
                        state_next = S_RELOAD;
                    end
                    else
                    begin
                        res_status_next = ST_NO_FIT;
                        state_next      = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                issue = (ptr_reg < count_reg);
                if (issue)
                begin
                    ram_raddr = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
                ev_vld_next = issue;
                ev_idx_next = ptr_reg[IDX_W-1:0];
                if (ev_vld_reg)
                begin
                    if (opcode_reg == OPC_RELEASE)
                    begin
                        take = rd_used && alu_flags.zero && !found_reg;
                    end
                    else
                    begin
                        better = (opcode_reg == OPC_BEST && alu_flags.c_lt_d) ||
                                 (opcode_reg == OPC_WORST && alu_flags.c_gt_d);
                        take   = !rd_used && !alu_flags.carry && (!found_reg || better);
                    end
                    if (take)
                    begin
                        found_next      = 1'b1;
                        pick_idx_next   = ev_idx_reg;
                        pick_start_next = rd_start;
                        pick_size_next  = rd_size;
                        pick_rem_next   = alu_res[SIZE_W-1:0];
                        pick_exact_next = alu_flags.zero;
                    end
                end
                if (!issue && !ev_vld_reg)
                begin
                    if (opcode_reg == OPC_RELEASE)
                    begin
                        if (!found_reg)
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            wptr_next  = '0;
                            state_next = S_MERGE;
                        end
                    end
                    else if (!found_reg)
                    begin
                        res_status_next = ST_NO_FIT;
                        state_next      = S_DONE;
                    end
                    else if (pick_exact_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else if (count_reg == CNT_W'(MAX_BLOCKS))
                    begin
                        res_status_next = ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ptr_next   = count_reg - CNT_W'(1);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // move entries behind the pick one place up, last one first
                issue = (ptr_reg > CNT_W'(pick_idx_reg));
                if (issue)
                begin
                    ram_raddr = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg - CNT_W'(1);
                end
                ev_vld_next = issue;
                ev_idx_next = ptr_reg[IDX_W-1:0];
                if (ev_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ev_idx_reg + IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (!issue && !ev_vld_reg)
                begin
                    state_next = S_SPLIT;
                end
            end

            S_SPLIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pick_idx_reg + IDX_W'(1);
                ram_wdata  = {1'b0, pick_rem_reg, alu_res[ADDR_WIDTH-1:0]};
                count_next = count_reg + CNT_W'(1);
                state_next = S_MARK;
            end

            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_waddr = pick_idx_reg;
                ram_wdata = {1'b1, pick_exact_reg ? pick_size_reg : req_x[SIZE_W-1:0],
                             pick_start_reg};
                res_status_next  = ST_ALLOCATED;
                res_granted_next = pick_start_x[FIELD_W-1:0];
                state_next       = S_DONE;
            end

            S_MERGE:
            begin
                // compact the table, the released entry reads as free
                issue = (ptr_reg < count_reg);
                if (issue)
                begin
                    ram_raddr = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
                ev_vld_next = issue;
                ev_idx_next = ptr_reg[IDX_W-1:0];
                if (ev_vld_reg)
                begin
                    e_used = rd_used && (ev_idx_reg != pick_idx_reg);
                    if (ev_idx_reg == '0)
                    begin
                        hold_start_next = rd_start;
                        hold_size_next  = rd_size;
                        hold_used_next  = e_used;
                    end
                    else if (!hold_used_reg && !e_used)
                    begin
                        hold_size_next = alu_res[SIZE_W-1:0];
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = wptr_reg;
                        ram_wdata       = {hold_used_reg, hold_size_reg, hold_start_reg};
                        wptr_next       = wptr_reg + IDX_W'(1);
                        hold_start_next = rd_start;
                        hold_size_next  = rd_size;
                        hold_used_next  = e_used;
                    end
                end
                if (!issue && !ev_vld_reg)
                begin
                    state_next = S_MERGE_END;
                end
            end

            S_MERGE_END:
            begin
                ram_we          = 1'b1;
                ram_waddr       = wptr_reg;
                ram_wdata       = {hold_used_reg, hold_size_reg, hold_start_reg};
                count_next      = CNT_W'(wptr_reg) + CNT_W'(1);
                res_status_next = ST_RELEASED;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next                = 1'b1;
                    rsp_data_next.status          = res_status_reg;
                    rsp_data_next.granted_address = res_granted_reg;
                    rsp_data_next.entries_in_use  = cnt_wide[CNT_OUT_W-1:0];
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            count_reg       <= '0;
            opcode_reg      <= '0;
            req_size_reg    <= '0;
            addr_reg        <= '0;
            ptr_reg         <= '0;
            ev_vld_reg      <= 1'b0;
            ev_idx_reg      <= '0;
            found_reg       <= 1'b0;
            pick_idx_reg    <= '0;
            pick_start_reg  <= '0;
            pick_size_reg   <= '0;
            pick_rem_reg    <= '0;
            pick_exact_reg  <= 1'b0;
            hold_start_reg  <= '0;
            hold_size_reg   <= '0;
            hold_used_reg   <= 1'b0;
            wptr_reg        <= '0;
            acc_reg         <= '0;
            part_reg        <= '0;
            res_status_reg  <= ST_NO_FIT;
            res_granted_reg <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            opcode_reg      <= opcode_next;
            req_size_reg    <= req_size_next;
            addr_reg        <= addr_next;
            ptr_reg         <= ptr_next;
            ev_vld_reg      <= ev_vld_next;
            ev_idx_reg      <= ev_idx_next;
            found_reg       <= found_next;
            pick_idx_reg    <= pick_idx_next;
            pick_start_reg  <= pick_start_next;
            pick_size_reg   <= pick_size_next;
            pick_rem_reg    <= pick_rem_next;
            pick_exact_reg  <= pick_exact_next;
            hold_start_reg  <= hold_start_next;
            hold_size_reg   <= hold_size_next;
            hold_used_reg   <= hold_used_next;
            wptr_reg        <= wptr_next;
            acc_reg         <= acc_next;
            part_reg        <= part_next;
            res_status_reg  <= res_status_next;
            res_granted_reg <= res_granted_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_data_reg    <= rsp_data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vpa_checker.sv
// port level checker of the allocator and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module vpa_checker #(
    parameter int MAX_BLOCKS = vpa_pkg::MAX_BLOCKS_DEF
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire vpa_pkg::req_t req_data,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire vpa_pkg::rsp_t rsp_data
);
    import vpa_pkg::*;

    // a waiting request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("request changed while waiting");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

    // one transaction in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

    // only a grant carries an address
    a_granted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_ALLOCATED |-> rsp_data.granted_address == '0)
    else $error("address shown without grant");

    // table never reports more entries than it holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> int'(rsp_data.entries_in_use) <= MAX_BLOCKS)
    else $error("entry count beyond table depth");

endmodule

bind variable_partition_allocator vpa_checker #(
    .MAX_BLOCKS (MAX_BLOCKS)
) u_vpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: tb/sv/vpa_tb_pkg.sv
// testbench package with the allocation table tracker and its response checks
`timescale 1ns / 1ps

package vpa_tb_pkg;

    import vpa_pkg::*;

    class alloc_tracker;
        logic [PART_W-1:0]  part_size [PARTITIONS_DEF];
        logic [FIELD_W-1:0] blk_start [MAX_BLOCKS_DEF];
        logic [FIELD_W-1:0] blk_size  [MAX_BLOCKS_DEF];
        bit                 blk_used  [MAX_BLOCKS_DEF];
        int unsigned        blk_count;
        rsp_t               awaited_rsp [$];
        int unsigned        mismatches;

        function new();
            part_size  = '{14'd100, 14'd200, 14'd50, 14'd0};
            blk_count  = 0;
            mismatches = 0;
            rebuild();
        endfunction

        function void set_partition(int unsigned idx, logic [PART_W-1:0] val);
            if (idx < PARTITIONS_DEF)
                part_size[idx] = val;
        endfunction

        // lay the partitions out back to back from address zero
        function void rebuild();
            logic [FIELD_W-1:0] addr;
            addr      = '0;
            blk_count = 0;
            foreach (blk_used[i])
                blk_used[i] = 1'b0;
            for (int p = 0; p < PARTITIONS_DEF; p++)
            begin
                if (part_size[p] == '0)
                    continue;
                if (blk_count < MAX_BLOCKS_DEF)
                begin
                    blk_start[blk_count] = addr;
                    blk_size[blk_count]  = FIELD_W'(part_size[p]);
                    blk_used[blk_count]  = 1'b0;
                    blk_count++;
                end
                addr = addr + FIELD_W'(part_size[p]);
            end
        endfunction

        function void drop_entry(int unsigned pos);
            for (int unsigned k = pos; k + 1 < blk_count; k++)
            begin
                blk_start[k] = blk_start[k + 1];
                blk_size[k]  = blk_size[k + 1];
                blk_used[k]  = blk_used[k + 1];
            end
            blk_count--;
        endfunction

        function void coalesce();
            int unsigned i;
            i = 0;
            while (i + 1 < blk_count)
            begin
                if (!blk_used[i] && !blk_used[i + 1])
                begin
                    blk_size[i] = blk_size[i] + blk_size[i + 1];
                    drop_entry(i + 1);
                end
                else
                    i++;
            end
        endfunction

        function status_t allocate(logic [OPC_W-1:0] mode, logic [FIELD_W-1:0] want,
                                   output logic [FIELD_W-1:0] granted);
            bit          found;
            int unsigned pick;
            found   = 1'b0;
            pick    = 0;
            granted = '0;
            if (want == '0)
                return ST_NO_FIT;
            for (int unsigned i = 0; i < blk_count; i++)
            begin
                if (blk_used[i] || blk_size[i] < want)
                    continue;
                if (!found)
                begin
                    found = 1'b1;
                    pick  = i;
                    if (mode == OPC_FIRST)
                        break;
                end
                else if (mode == OPC_BEST && blk_size[i] < blk_size[pick])
                    pick = i;
                else if (mode == OPC_WORST && blk_size[i] > blk_size[pick])
                    pick = i;
            end
            if (!found)
                return ST_NO_FIT;
            if (blk_size[pick] > want)
            begin
                if (blk_count >= MAX_BLOCKS_DEF)
                    return ST_TABLE_FULL;
                for (int unsigned k = blk_count; k > pick + 1; k--)
                begin
                    blk_start[k] = blk_start[k - 1];
                    blk_size[k]  = blk_size[k - 1];
                    blk_used[k]  = blk_used[k - 1];
                end
                blk_start[pick + 1] = blk_start[pick] + want;
                blk_size[pick + 1]  = blk_size[pick] - want;
                blk_used[pick + 1]  = 1'b0;
                blk_size[pick]      = want;
                blk_count++;
            end
            blk_used[pick] = 1'b1;
            granted        = blk_start[pick];
            return ST_ALLOCATED;
        endfunction

        function status_t release_at(logic [FIELD_W-1:0] addr);
            for (int unsigned i = 0; i < blk_count; i++)
            begin
                if (blk_used[i] && blk_start[i] == addr)
                begin
                    blk_used[i] = 1'b0;
                    coalesce();
                    return ST_RELEASED;
                end
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_request(req_t item);
            rsp_t               exp;
            status_t            st;
            logic [FIELD_W-1:0] granted;
            granted = '0;
            case (item.opcode)
                OPC_FIRST, OPC_BEST, OPC_WORST:
                    st = allocate(item.opcode, item.request_size, granted);
                OPC_RELEASE:
                    st = release_at(item.release_address);
                OPC_RELOAD:
                begin
                    rebuild();
                    st = ST_RELOADED;
                end
                default:
                    st = ST_NO_FIT;
            endcase
            if (st != ST_ALLOCATED)
                granted = '0;
            exp.status          = st;
            exp.granted_address = granted;
            exp.entries_in_use  = CNT_OUT_W'(blk_count);
            awaited_rsp = {awaited_rsp, exp};
        endfunction

        task report_mismatch(string what);
            if (mismatches < 40)
                $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t exp;
            if (awaited_rsp.size() == 0)
            begin
                report_mismatch($sformatf("response with none pending, status %0d", got.status));
                return;
            end
            exp = awaited_rsp.pop_front();
            if (got.status !== exp.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, exp.status));
            if (got.granted_address !== exp.granted_address)
                report_mismatch($sformatf("granted_address %0h, want %0h",
                                          got.granted_address, exp.granted_address));
            if (got.entries_in_use !== exp.entries_in_use)
                report_mismatch($sformatf("entries_in_use %0d, want %0d",
                                          got.entries_in_use, exp.entries_in_use));
        endtask

        function int unsigned pending();
            return awaited_rsp.size();
        endfunction

        function bit pick_used_start(output logic [FIELD_W-1:0] addr);
            int unsigned used_idx [$];
            addr = '0;
            for (int unsigned i = 0; i < blk_count; i++)
                if (blk_used[i])
                    used_idx = {used_idx, i};
            if (used_idx.size() == 0)
                return 1'b0;
            addr = blk_start[used_idx[$urandom_range(0, used_idx.size() - 1)]];
            return 1'b1;
        endfunction

        function int unsigned largest_partition();
            int unsigned top;
            top = 0;
            foreach (part_size[p])
                if (part_size[p] > top)
                    top = part_size[p];
            return top;
        endfunction
    endclass

endpackage

FILE: tb/sv/testbench.sv
// top level testbench of the variable partition allocator
`timescale 1ns / 1ps

module testbench;

    import vpa_pkg::*;
    import vpa_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 60;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PART_W-1:0]    cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp_data;

    alloc_tracker tracker;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left  = 0;
    ready_mode_t  ready_mode  = READY_ALWAYS;
    int unsigned  ready_span  = 0;
    int unsigned  ready_phase = 0;

    variable_partition_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // response side stall pattern
    always @(posedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(READY_ALWAYS, READY_PERIODIC));
            ready_span = $urandom_range(16, 160);
        end
        else
            ready_span = ready_span - 1;
        ready_phase = ready_phase + 1;
        case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ready <= (ready_phase % 7) < 3;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_response(rsp_data);
    end

    function automatic req_t make_req(logic [OPC_W-1:0] opc, logic [FIELD_W-1:0] size,
                                      logic [FIELD_W-1:0] addr);
        req_t item;
        item.opcode          = opc;
        item.request_size    = size;
        item.release_address = addr;
        return item;
    endfunction

    function automatic int unsigned next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
        return $urandom_range(1, 9);
    endfunction

    function automatic req_t random_request();
        req_t               item;
        logic [FIELD_W-1:0] addr;
        int unsigned        pick;
        int unsigned        sz_pick;
        int unsigned        top;
        item.request_size    = FIELD_W'($urandom);
        item.release_address = FIELD_W'($urandom);
        top = tracker.largest_partition();
        if (top == 0)
            top = 1;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            item.opcode = OPC_W'($urandom_range(OPC_FIRST, OPC_WORST));
            sz_pick = $urandom_range(0, 99);
            if (sz_pick < 45)
                item.request_size = FIELD_W'($urandom_range(1, 16));
            else if (sz_pick < 75)
                item.request_size = FIELD_W'($urandom_range(1, top));
            else if (sz_pick < 90)
                item.request_size = FIELD_W'($urandom_range(1, (top * 2 > 65535) ? 65535 : top * 2));
            else if (sz_pick < 96)
                item.request_size = FIELD_W'($urandom);
            else
                item.request_size = '0;
        end
        else if (pick < 92)
        begin
            item.opcode = OPC_RELEASE;
            if ($urandom_range(0, 4) != 0 && tracker.pick_used_start(addr))
                item.release_address = addr;
        end
        else if (pick < 96)
            item.opcode = OPC_RELOAD;
        else
            item.opcode = OPC_W'($urandom_range(OPC_RELOAD + 1, {OPC_W{1'b1}}));
        return item;
    endfunction

    task automatic send_item(input req_t item);
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        tracker.note_request(item);
    endtask

    task automatic issue(input req_t item);
        int unsigned gap;
        send_item(item);
        gap = next_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain(input int unsigned settle);
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic program_partitions(input logic [PART_W-1:0] sizes [PARTITIONS_DEF],
                                      input bit stray);
        logic [CFG_IDX_W-1:0] idx;
        logic [PART_W-1:0]    val;
        for (int i = 0; i <= PARTITIONS_DEF; i++)
        begin
            if (i == PARTITIONS_DEF && !stray)
                break;
            if (i < PARTITIONS_DEF)
            begin
                idx = CFG_IDX_W'(i);
                val = sizes[i];
            end
            else
            begin
                idx = CFG_IDX_W'($urandom_range(PARTITIONS_DEF, (1 << CFG_IDX_W) - 1));
                val = PART_W'($urandom);
            end
            cfg_wen   <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            tracker.set_partition(idx, val);
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            issue(random_request());
            if ($urandom_range(0, 149) == 0)
                drain(0);
        end
    endtask

    task automatic start_phase(input logic [PART_W-1:0] sizes [PARTITIONS_DEF],
                               input int unsigned count);
        drain(SETTLE_CYCLES);
        program_partitions(sizes, $urandom_range(0, 1));
        issue(make_req(OPC_RELOAD, FIELD_W'($urandom), FIELD_W'($urandom)));
        run_random(count);
    endtask

    initial
    begin
        logic [PART_W-1:0] sizes [PARTITIONS_DEF];
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed transactions on the reset table
        issue(make_req(OPC_FIRST, 16'd30, 16'h0000));
        issue(make_req(OPC_BEST, 16'd40, 16'h0000));
        issue(make_req(OPC_WORST, 16'd150, 16'h0000));
        issue(make_req(OPC_FIRST, 16'd0, 16'hFFFF));
        issue(make_req(OPC_BEST, 16'hFFFF, 16'h0000));
        issue(make_req(OPC_RELEASE, 16'h0000, 16'hFFFF));
        issue(make_req(OPC_RELEASE, 16'hFFFF, 16'h0000));
        for (int op = OPC_RELOAD + 1; op < (1 << OPC_W); op++)
            issue(make_req(OPC_W'(op), 16'hFFFF, 16'hFFFF));
        issue(make_req(OPC_RELOAD, 16'h0000, 16'h0000));
        // fill the table with single unit blocks
        for (int n = 0; n < 13; n++)
            issue(make_req(OPC_FIRST, 16'd1, 16'h0000));
        issue(make_req(OPC_FIRST, 16'd87, 16'h0000));
        issue(make_req(OPC_WORST, 16'd1, 16'h0000));
        issue(make_req(OPC_RELEASE, 16'h0000, 16'd5));
        issue(make_req(OPC_RELOAD, 16'h0000, 16'h0000));

        run_random(300);

        sizes = '{14'd0, 14'd0, 14'd0, 14'd0};
        start_phase(sizes, 40);
        sizes = '{14'd16383, 14'd16383, 14'd16383, 14'd16383};
        start_phase(sizes, 250);
        sizes = '{14'd1, 14'd1, 14'd1, 14'd1};
        start_phase(sizes, 150);
        for (int ph = 0; ph < 3; ph++)
        begin
            foreach (sizes[p])
            begin
                if ($urandom_range(0, 3) == 0)
                    sizes[p] = '0;
                else if ($urandom_range(0, 1) == 0)
                    sizes[p] = PART_W'($urandom_range(1, 64));
                else
                    sizes[p] = PART_W'($urandom_range(1, 16383));
            end
            start_phase(sizes, 170);
        end

        drain(DRAIN_CYCLES);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/vpa_pkg.sv
rtl/core/vpa_ram.sv
rtl/core/vpa_alu.sv
rtl/core/vpa_seq.sv
rtl/core/variable_partition_allocator.sv
rtl/core/vpa_checker.sv
tb/sv/vpa_tb_pkg.sv
tb/sv/testbench.sv
